@@ sv/mss_pkg.sv @@
// Shared definitions for the max-bubbling selection sorter.
// Holds the sequencer state type and state codes; no dependencies.
package mss_pkg;

    localparam int STATE_W = 3;
    typedef logic [STATE_W-1:0] t_state;

    localparam t_state ST_LOAD    = 3'd0;
    localparam t_state ST_SCAN    = 3'd1;
    localparam t_state ST_SWAP_A  = 3'd2;
    localparam t_state ST_SWAP_B  = 3'd3;
    localparam t_state ST_EMIT_RD = 3'd4;
    localparam t_state ST_EMIT_LD = 3'd5;
    localparam t_state ST_EMIT_HD = 3'd6;

endpackage

@@ sv/mss_ram.sv @@
// Element store of the sorter: one write port, one read port with registered data.
// No package dependencies.
module mss_ram #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [VALUE_BITS-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [VALUE_BITS-1:0]    o_rdata
);

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/max_bubbling_selection_sorter.sv @@
// Max-bubbling selection sorter: loads a set, sorts it in place, streams it out ascending.
// Loaded requests are written to the store while there is room; a sort pass over the unsorted
// entries scans them through the single read port, then makes two writes. Each result is then
// read, loaded and held until taken. Throughput: one set at a time, no requests taken
// while a set is sorted or emitted. Depends on mss_pkg and mss_ram.
// Reset (i_rst_n low, synchronous) clears sequencer, count and overflow flag, not the store.
module max_bubbling_selection_sorter #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   i_s_axis_tdata,  // [VALUE_BITS-1:0] value
    input  logic                              i_s_axis_tlast,  // last_in
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]   o_m_axis_tdata,  // [VALUE_BITS-1:0] sorted_value
    output logic                              o_m_axis_tlast,  // last_out
    output logic                              o_m_axis_tuser   // overflow
);

    localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // sequencer and counters
    mss_pkg::t_state         r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;     // values held in the store
    logic                    r_ovf, n_ovf;         // a value was dropped this set
    logic [IDX_W-1:0]        r_end, n_end;         // last unsorted position
    logic [IDX_W-1:0]        r_addr, n_addr;       // read address being issued
    logic                    r_stop, n_stop;       // scan has issued its final read
    logic                    r_pend, n_pend;       // read data returns this cycle
    logic [IDX_W-1:0]        r_pidx, n_pidx;       // index of the returning data
    // pass payload
    logic [VALUE_BITS-1:0]   r_max, n_max;
    logic [IDX_W-1:0]        r_big, n_big;
    logic [VALUE_BITS-1:0]   r_endval, n_endval;
    // output register
    logic                    r_ovalid, n_ovalid;
    logic [VALUE_BITS-1:0]   r_odata, n_odata;
    logic                    r_olast, n_olast;

    // store port
    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    logic [VALUE_BITS-1:0]   w_wdata;
    logic [VALUE_BITS-1:0]   w_rdata;

    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_room;
    logic [CNT_W-1:0]        w_cnt_inc;

    mss_ram #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == mss_pkg::ST_LOAD);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = r_ovalid && i_m_axis_tready;
    assign w_room          = (r_count < CNT_W'(DEPTH));
    assign w_cnt_inc       = r_count + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_end    = r_end;
        n_addr   = r_addr;
        n_stop   = r_stop;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_max    = r_max;
        n_big    = r_big;
        n_endval = r_endval;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_olast  = r_olast;
        w_we     = 1'b0;
        w_waddr  = r_count[IDX_W-1:0];
        w_wdata  = i_s_axis_tdata[VALUE_BITS-1:0];

        unique case (r_state)
            mss_pkg::ST_LOAD: begin
                if (w_in_acc) begin
                    // store while there is room, otherwise drop and flag
                    if (w_room) begin
                        w_we    = 1'b1;
                        n_count = w_cnt_inc;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_addr = '0;
                        n_stop = 1'b0;
                        n_end  = w_room ? r_count[IDX_W-1:0] : IDX_W'(DEPTH - 1);
                        // a single unsorted entry left means the set is sorted
                        if ((w_room && r_count == '0) || (!w_room && DEPTH == 1)) begin
                            n_state = mss_pkg::ST_EMIT_RD;
                        end else begin
                            n_state = mss_pkg::ST_SCAN;
                        end
                    end
                end
            end
            mss_pkg::ST_SCAN: begin
                // issue reads 0..end, one a cycle
                if (!r_stop) begin
                    n_pend = 1'b1;
                    n_pidx = r_addr;
                    if (r_addr == r_end) begin
                        n_stop = 1'b1;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end
                // track the first maximum as data returns
                if (r_pend) begin
                    if (r_pidx == '0 || w_rdata > r_max) begin
                        n_max = w_rdata;
                        n_big = r_pidx;
                    end
                    if (r_pidx == r_end) begin
                        n_endval = w_rdata;
                        n_state  = mss_pkg::ST_SWAP_A;
                    end
                end
            end
            mss_pkg::ST_SWAP_A: begin
                // move the maximum to the last unsorted position
                w_we    = 1'b1;
                w_waddr = r_end;
                w_wdata = r_max;
                n_state = mss_pkg::ST_SWAP_B;
            end
            mss_pkg::ST_SWAP_B: begin
                // put the displaced value where the maximum was
                w_we    = 1'b1;
                w_waddr = r_big;
                w_wdata = r_endval;
                n_end   = r_end - IDX_W'(1);
                n_addr  = '0;
                n_stop  = 1'b0;
                if (r_end == IDX_W'(1)) begin
                    n_state = mss_pkg::ST_EMIT_RD;
                end else begin
                    n_state = mss_pkg::ST_SCAN;
                end
            end
            mss_pkg::ST_EMIT_RD: begin
                // read address is presented this cycle
                n_state = mss_pkg::ST_EMIT_LD;
            end
            mss_pkg::ST_EMIT_LD: begin
                n_odata  = w_rdata;
                n_olast  = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);
                n_ovalid = 1'b1;
                n_state  = mss_pkg::ST_EMIT_HD;
            end
            mss_pkg::ST_EMIT_HD: begin
                // hold the result until taken
                if (w_out_acc) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = mss_pkg::ST_LOAD;
                    end else begin
                        n_addr  = r_addr + IDX_W'(1);
                        n_state = mss_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = mss_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mss_pkg::ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_end    <= '0;
            r_addr   <= '0;
            r_stop   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_end    <= n_end;
            r_addr   <= n_addr;
            r_stop   <= n_stop;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_max    <= n_max;
        r_big    <= n_big;
        r_endval <= n_endval;
        r_odata  <= n_odata;
        r_olast  <= n_olast;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = DATA_W'(r_odata);
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ovf;

    // a result is only offered while the emitter holds it
    a_valid_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_state == mss_pkg::ST_EMIT_HD))
        else $error("result valid outside emit hold");

    // the store never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count exceeds depth");

    // the selected maximum lies within the unsorted prefix
    a_big_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mss_pkg::ST_SWAP_A) |-> (r_big <= r_end))
        else $error("maximum index beyond unsorted prefix");

    // a taken last result returns the block to loading with cleared flags
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_olast) |=> (o_s_axis_tready && r_count == '0 && !r_ovf))
        else $error("set not closed after last result");

endmodule
